### src/kmd_pkg.sv
package kmd_pkg;

	localparam int NUM_COLUMNS = 3;
	localparam int COL_W       = 2;
	localparam int ROW_W       = 4;
	localparam int RAW_W       = 8;
	localparam int CODE_W      = NUM_COLUMNS * ROW_W;

	// Column code that marks "no key held".
	localparam logic [COL_W-1:0] NO_COLUMN = 2'd3;
	// Port bits 0 and 7 never count as pressed.
	localparam logic [RAW_W-1:0] RAW_IGNORE_MASK = 8'h81;

	typedef logic [ROW_W-1:0] row_t;
	typedef logic [COL_W-1:0] col_t;

	typedef struct packed {
		logic              key_event;
		logic [CODE_W-1:0] key_code;
		col_t              drive_column;
	} result_t;

endpackage

### src/kmd_sample_if.sv
interface kmd_sample_if import kmd_pkg::*;;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_lines;

	modport source (output valid, output raw_lines, input ready);
	modport sink   (input valid, input raw_lines, output ready);
endinterface

### src/kmd_result_if.sv
interface kmd_result_if import kmd_pkg::*;;
	logic              valid;
	logic              ready;
	logic              key_event;
	logic [CODE_W-1:0] key_code;
	col_t              drive_column;

	modport source (output valid, output key_event, output key_code, output drive_column,
		input ready);
	modport sink   (input valid, input key_event, input key_code, input drive_column,
		output ready);
endinterface

### src/kmd_history_mem.sv
module kmd_history_mem import kmd_pkg::*; #(
	parameter int ENTRIES = 30,
	parameter int ADDR_W  = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  row_t              wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output row_t              rdata
);

	row_t              mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	row_t              rdata_q;

	// An entry that was never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= valid_q[raddr] ? mem[raddr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

### src/kmd_seq.sv
module kmd_seq import kmd_pkg::*; #(
	parameter int HISTORY_DEPTH = 10,
	parameter int ADDR_W        = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAW_W-1:0]  raw_lines,
	output logic              idle,
	input  logic              out_free,
	output logic              done,
	output result_t           result,
	output logic              mem_we,
	output logic [ADDR_W-1:0] mem_waddr,
	output row_t              mem_wdata,
	output logic              mem_re,
	output logic [ADDR_W-1:0] mem_raddr,
	input  row_t              mem_rdata
);

	localparam int SLOT_W = $clog2(HISTORY_DEPTH);
	localparam int LAST_K = HISTORY_DEPTH + NUM_COLUMNS - 1;
	localparam int CNT_W  = $clog2(LAST_K + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]        state_q;
	col_t              cur_col_q;
	logic [SLOT_W-1:0] slot_q;
	col_t              col_q;
	col_t              held_q;
	logic [CODE_W-1:0] last_code_q;
	row_t              rows_q;
	logic              release_q;
	logic              stable_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              issued_all_q;
	logic              rd_vld_s1;
	logic [CNT_W-1:0]  rd_tag_s1;
	row_t              nib_q [NUM_COLUMNS];

	row_t              rows_in;
	logic              issue;
	logic              in_history;
	col_t              rd_col;
	logic [SLOT_W-1:0] rd_slot;
	logic [CODE_W-1:0] key;
	logic              key_new;
	logic              held_match;

	assign rows_in = row_t'(~(raw_lines | RAW_IGNORE_MASK) >> ROW_W);

	assign idle = (state_q == ST_IDLE);

	// Write the new sample into its history slot on the accepting edge.
	assign mem_we    = start;
	assign mem_waddr = ADDR_W'(cur_col_q) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(slot_q);
	assign mem_wdata = rows_in;

	// Read order: every slot of the sampled column, then slot 1 of each column.
	assign issue      = (state_q == ST_SCAN) && !issued_all_q;
	assign in_history = (rd_cnt_q < CNT_W'(HISTORY_DEPTH));
	assign rd_col     = in_history ? col_q : COL_W'(rd_cnt_q - CNT_W'(HISTORY_DEPTH));
	assign rd_slot    = in_history ? SLOT_W'(rd_cnt_q) : SLOT_W'(1);
	assign mem_re     = issue;
	assign mem_raddr  = ADDR_W'(rd_col) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(rd_slot);

	assign key        = {nib_q[2], nib_q[1], nib_q[0]};
	assign key_new    = (key != last_code_q);
	assign held_match = (col_q == held_q);

	assign done = (state_q == ST_FINISH) && out_free;

	always_comb begin
		result.drive_column = cur_col_q;
		result.key_event    = 1'b0;
		result.key_code     = '0;
		if (release_q) begin
			result.key_event = held_match;
		end else if (stable_q) begin
			result.key_event = key_new;
			result.key_code  = key_new ? key : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_col_q    <= '0;
			slot_q       <= '0;
			held_q       <= NO_COLUMN;
			last_code_q  <= '0;
			rd_cnt_q     <= '0;
			issued_all_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (cur_col_q == COL_W'(NUM_COLUMNS - 1)) begin
							cur_col_q <= '0;
							slot_q    <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
								: slot_q + SLOT_W'(1);
						end else begin
							cur_col_q <= cur_col_q + COL_W'(1);
						end
						rd_cnt_q     <= '0;
						issued_all_q <= 1'b0;
						state_q      <= (rows_in == '0) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						if (rd_cnt_q == CNT_W'(LAST_K)) begin
							issued_all_q <= 1'b1;
						end else begin
							rd_cnt_q <= rd_cnt_q + CNT_W'(1);
						end
					end
					if (rd_vld_s1 && rd_tag_s1 == CNT_W'(LAST_K)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						if (release_q) begin
							if (held_match) begin
								held_q      <= NO_COLUMN;
								last_code_q <= '0;
							end
						end else if (stable_q) begin
							held_q      <= col_q;
							last_code_q <= key;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-item working registers.
	always_ff @(posedge clk) begin
		if (start) begin
			col_q     <= cur_col_q;
			rows_q    <= rows_in;
			release_q <= (rows_in == '0);
			stable_q  <= 1'b1;
		end else if (rd_vld_s1 && rd_tag_s1 < CNT_W'(HISTORY_DEPTH)) begin
			// All slots equal each other exactly when they all equal the new sample.
			if (mem_rdata != rows_q) begin
				stable_q <= 1'b0;
			end
		end
		if (rd_vld_s1 && rd_tag_s1 >= CNT_W'(HISTORY_DEPTH)) begin
			nib_q[COL_W'(rd_tag_s1 - CNT_W'(HISTORY_DEPTH))] <= mem_rdata;
		end
		if (issue) begin
			rd_tag_s1 <= rd_cnt_q;
		end
	end

endmodule

### src/keypad_matrix_debounce_scanner.sv
// Channel   Dir  Payload                                   Handshake
// sample    in   raw_lines[7:0]                            valid / ready
// result    out  key_event, key_code[11:0], drive_column   valid / ready
//
// A sample item that shows a pressed row is scanned through the single read port
// of the history memory: every slot of the sampled column is read once, then slot
// 1 of each of the three columns, one read per cycle. A sample whose column reads
// empty skips the reads and goes straight to its result.
// Reset clears the history through per-entry valid bits, so no clearing pass runs.
// A finished result waits in the output register; the next sample is taken as soon
// as that result is loaded, and a result that is not taken holds off the one after.
module keypad_matrix_debounce_scanner import kmd_pkg::*; #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	kmd_sample_if.sink    sample,
	kmd_result_if.source  result
);

	localparam int ENTRIES = NUM_COLUMNS * HISTORY_DEPTH;
	localparam int ADDR_W  = $clog2(ENTRIES);

	logic              seq_idle;
	logic              seq_done;
	logic              start;
	logic              out_free;
	result_t           seq_result;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	row_t              mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	row_t              mem_rdata;

	logic              out_valid_q;
	result_t           out_q;

	// The sequencer takes a new sample only while it has nothing in flight.
	assign sample.ready = seq_idle;
	assign start        = sample.valid && seq_idle;

	// The output register is free when empty or when its item leaves this cycle.
	assign out_free = !out_valid_q || result.ready;

	kmd_history_mem #(
		.ENTRIES (ENTRIES),
		.ADDR_W  (ADDR_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

	kmd_seq #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.ADDR_W        (ADDR_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.raw_lines (sample.raw_lines),
		.idle      (seq_idle),
		.out_free  (out_free),
		.done      (seq_done),
		.result    (seq_result),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Every sample yields exactly one result item, held here until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_done) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			out_q <= seq_result;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.key_event    = out_q.key_event;
	assign result.key_code     = out_q.key_code;
	assign result.drive_column = out_q.drive_column;

endmodule

### sim/keypad_matrix_debounce_scanner_test.sv
`timescale 1ns / 1ps

// Testbench for the keypad matrix scanner. A short table of samples runs first.
// Random key presses follow: a pattern is held for about ten full scans so that
// the debounce history settles, then released. Some of these carry contact
// bounce, and some switch straight to a new pattern. Random bytes are mixed in
// as noise. Every sample gives exactly one result item. The expected value comes
// from the predictor below and is compared field by field in the order of arrival.
module keypad_matrix_debounce_scanner_test import kmd_pkg::*;;

	localparam int HIST_DEPTH    = 10;
	localparam int RANDOM_ITEMS  = 1100;
	localparam int MAX_REPORTS   = 100;
	localparam int IDLE_PCT      = 35;
	// Four slow sample items. Nothing is still in flight after the
	// last expected result, so this only catches late surplus results.
	localparam int DRAIN_CYCLES  = 4 * (HIST_DEPTH + 6);

	typedef struct {
		logic [RAW_W-1:0] raw;
		bit               typed;
		result_t          want;
	} sample_row_t;

	logic clk;
	logic arst_n;

	kmd_sample_if sample_ch ();
	kmd_result_if result_ch ();

	keypad_matrix_debounce_scanner #(
		.HISTORY_DEPTH(HIST_DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	// Predictor state. It mirrors the scanner after reset: an empty history,
	// column 0, slot 0, no key held and no code reported yet.
	row_t              history [NUM_COLUMNS][HIST_DEPTH];
	int                write_slot;
	col_t              cur_col;
	col_t              held_col;
	logic [CODE_W-1:0] last_code;

	result_t pending_results [$];
	int      mismatch_count;
	int      items_sent;
	// While calm is set, neither side inserts random idle cycles.
	bit      calm;
	result_t got;
	result_t want;

	// Directed samples. Nothing can settle in the first nine scans after reset,
	// since the cleared history still holds zeros. So no row here gives an event.
	// Only the first rows carry a typed expectation. Bits 0 to 3 and bit 7 never
	// count, so FF and 7E read as an empty column, while 00, 0F and 81 press
	// rows 0 to 2.
	sample_row_t sample_table [24] = '{
		'{8'hFF, 1'b1, '{1'b0, 12'h000, 2'd1}},
		'{8'h00, 1'b1, '{1'b0, 12'h000, 2'd2}},
		'{8'h81, 1'b1, '{1'b0, 12'h000, 2'd0}},
		'{8'h7E, 1'b1, '{1'b0, 12'h000, 2'd1}},
		'{8'hEF, 1'b0, '0},
		'{8'hDF, 1'b0, '0},
		'{8'hBF, 1'b0, '0},
		'{8'h7F, 1'b0, '0},
		'{8'hFE, 1'b0, '0},
		'{8'hF0, 1'b0, '0},
		'{8'h0F, 1'b0, '0},
		'{8'h8F, 1'b0, '0},
		'{8'h55, 1'b0, '0},
		'{8'hAA, 1'b0, '0},
		'{8'h3C, 1'b0, '0},
		'{8'hC3, 1'b0, '0},
		'{8'h01, 1'b0, '0},
		'{8'h80, 1'b0, '0},
		'{8'h10, 1'b0, '0},
		'{8'h20, 1'b0, '0},
		'{8'h40, 1'b0, '0},
		'{8'h8E, 1'b0, '0},
		'{8'h71, 1'b0, '0},
		'{8'hE1, 1'b0, '0}
	};

	// One scan step. The sample is stored in the history of the current column.
	// An empty read of the held column is a release. A nonzero column whose
	// whole history agrees gives the code from slot 1 of every column, and the
	// code is reported only when it differs from the last one reported.
	function automatic result_t scan_column(input logic [RAW_W-1:0] raw);
		logic [RAW_W-1:0]  inverted;
		row_t              rows;
		int                col;
		int                slot;
		bit                steady;
		logic [CODE_W-1:0] code_now;
		result_t           res;
		res      = '0;
		col      = (cur_col >= NUM_COLUMNS) ? 0 : int'(cur_col);
		slot     = (write_slot >= HIST_DEPTH) ? 0 : write_slot;
		inverted = ~(raw | RAW_IGNORE_MASK);
		rows     = inverted[7:4];
		history[col][slot] = rows;
		if (rows == '0) begin
			if (col_t'(col) == held_col) begin
				last_code     = '0;
				held_col      = NO_COLUMN;
				res.key_event = 1'b1;
			end
		end else begin
			steady = 1'b1;
			for (int j = 0; j < HIST_DEPTH; j++) begin
				if (history[col][j] != history[col][0])
					steady = 1'b0;
			end
			if (steady) begin
				code_now = {history[2][1], history[1][1], history[0][1]};
				held_col = col_t'(col);
				// A settled code that equals the last one is kept quiet.
				if (code_now != last_code) begin
					res.key_event = 1'b1;
					res.key_code  = code_now;
				end
				last_code = code_now;
			end
		end
		// The shared write slot moves on once every column has been sampled.
		if (col + 1 >= NUM_COLUMNS) begin
			col  = 0;
			slot = (slot + 1 >= HIST_DEPTH) ? 0 : slot + 1;
		end else begin
			col++;
		end
		cur_col          = col_t'(col);
		write_slot       = slot;
		res.drive_column = col_t'(col);
		return res;
	endfunction

	// Port byte for a row pattern. The lines are active low. Bit 7 and the low
	// nibble are random, since the scanner ignores them.
	function automatic logic [RAW_W-1:0] encode_rows(input row_t rows);
		return {1'($urandom_range(1)), ~rows[2:0], 4'($urandom_range(15))};
	endfunction

	// Offers one sample item after a random idle gap, waits for it to be
	// accepted, then records the expected result. The expectation is the typed
	// one where given and otherwise the predictor's. The predictor is stepped
	// either way, so its state stays in line with the scanner. The task returns
	// at a falling edge with valid still high. The next call then changes valid
	// only once in that time step.
	task automatic drive_sample(input logic [RAW_W-1:0] raw, input bit typed,
		input result_t expected);
		result_t predicted;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.raw_lines <= raw;
		do
			@(posedge clk);
		while (sample_ch.ready !== 1'b1);
		predicted = scan_column(raw);
		pending_results.push_back(typed ? expected : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The result side stalls at random. It is changed at the falling edge only.
	initial result_ch.ready = 1'b0;
	always @(negedge clk)
		result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	// Every result that is taken is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			got = '{result_ch.key_event, result_ch.key_code, result_ch.drive_column};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result with none expected: event %b code %h column %0d",
						$time, got.key_event, got.key_code, got.drive_column);
			end else begin
				want = pending_results.pop_front();
				if (got.key_event !== want.key_event || got.key_code !== want.key_code ||
					got.drive_column !== want.drive_column) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: expected %b %h %0d, got %b %h %0d", $time,
							want.key_event, want.key_code, want.drive_column,
							got.key_event, got.key_code, got.drive_column);
				end
			end
		end
	end

	initial begin : stimulus
		row_t             pattern [NUM_COLUMNS];
		logic [RAW_W-1:0] raw;
		int               kind;
		int               rounds;
		int               start_count;

		arst_n              = 1'b0;
		sample_ch.valid     = 1'b0;
		sample_ch.raw_lines = '0;
		calm                = 1'b0;
		mismatch_count      = 0;
		items_sent          = 0;
		foreach (history[c, s])
			history[c][s] = '0;
		write_slot = 0;
		cur_col    = '0;
		held_col   = NO_COLUMN;
		last_code  = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (sample_table[i])
			drive_sample(sample_table[i].raw, sample_table[i].typed, sample_table[i].want);

		// Hold off the sender until every result of the table has come.
		while (pending_results.size() != 0) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end

		start_count = items_sent;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			// A long stretch in the middle runs with no random idling on either side.
			calm = (items_sent - start_count >= 400) && (items_sent - start_count < 600);
			kind = $urandom_range(99);
			if (kind < 75) begin
				// A key press. Usually it is one column, and sometimes a second
				// column joins it. Most presses last long enough to settle, while
				// some are too short.
				foreach (pattern[c])
					pattern[c] = '0;
				pattern[$urandom_range(NUM_COLUMNS - 1)] = row_t'($urandom_range(1, 7));
				if ($urandom_range(3) == 0)
					pattern[$urandom_range(NUM_COLUMNS - 1)] = row_t'($urandom_range(1, 7));
				rounds = ($urandom_range(6) == 0) ? $urandom_range(2, HIST_DEPTH - 1)
					: $urandom_range(HIST_DEPTH, HIST_DEPTH + 4);
				repeat (rounds * NUM_COLUMNS) begin
					// Now and then a contact bounces and the port shows anything.
					if ($urandom_range(39) == 0)
						raw = RAW_W'($urandom);
					else
						raw = encode_rows(pattern[cur_col]);
					drive_sample(raw, 1'b0, '0);
				end
				// Most presses end with a release. Others go straight to the next
				// pattern, so a new code can replace the held one.
				if ($urandom_range(4) != 0) begin
					repeat ($urandom_range(1, 3) * NUM_COLUMNS)
						drive_sample(encode_rows('0), 1'b0, '0);
				end
			end else begin
				repeat ($urandom_range(3, 12))
					drive_sample(RAW_W'($urandom), 1'b0, '0);
			end
			if ($urandom_range(9) == 0) begin
				while (pending_results.size() != 0) begin
					sample_ch.valid <= 1'b0;
					@(negedge clk);
				end
			end
		end
		calm = 1'b0;
		sample_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// The slowest correct run stays well under a millisecond, so this only
	// ends a run that hangs.
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
src/kmd_pkg.sv
src/kmd_sample_if.sv
src/kmd_result_if.sv
src/kmd_history_mem.sv
src/kmd_seq.sv
src/keypad_matrix_debounce_scanner.sv
sim/keypad_matrix_debounce_scanner_test.sv
